FILE: rtl/core/derenc_pkg.sv
package derenc_pkg;

   localparam int unsigned FrameBytes = 10;
   localparam int unsigned CountWidth = 4;

   localparam logic [2:0] OP_INTEGER    = 3'd0;
   localparam logic [2:0] OP_BOOLEAN    = 3'd1;
   localparam logic [2:0] OP_BIT_STRING = 3'd2;
   localparam logic [2:0] OP_NULL       = 3'd3;
   localparam logic [2:0] OP_HEADER     = 3'd4;

   localparam logic [7:0] TAG_BOOLEAN    = 8'h01;
   localparam logic [7:0] TAG_INTEGER    = 8'h02;
   localparam logic [7:0] TAG_BIT_STRING = 8'h03;
   localparam logic [7:0] TAG_NULL       = 8'h05;
   localparam logic [7:0] TAG_LIMIT      = 8'h1F;
   localparam logic [7:0] LONG_FORM      = 8'h80;

   typedef struct packed {
      logic [2:0]  operation;
      logic [63:0] value;
      logic [1:0]  tag_class;
      logic        constructed;
      logic [7:0]  tag_number;
      logic [30:0] content_length;
   } req_type;

   typedef struct packed {
      logic [FrameBytes-1:0][7:0] data;
      logic [CountWidth-1:0]      count;
      logic                       error;
   } frame_type;

endpackage

FILE: rtl/core/derenc_encode.sv
module derenc_encode (
   input  derenc_pkg::req_type   req,
   output derenc_pkg::frame_type frame
);
   import derenc_pkg::*;

   function automatic logic [7:0] bit_reverse(input logic [7:0] v);
      logic [7:0] r;
      for (int i = 0; i < 8; i++) begin
         r[i] = v[7-i];
      end
      return r;
   endfunction

   logic [6:0]  redundant;
   logic [2:0]  start;
   logic        found;
   logic [63:0] int_shifted;
   logic [31:0] flags;
   logic [2:0]  flag_bytes;
   logic [7:0]  top_byte;
   logic [2:0]  top_pos;
   logic [2:0]  len_bytes;
   logic [31:0] len_shifted;

   // leading bytes that only repeat the sign of the next byte
   always_comb begin
      for (int i = 0; i < 7; i++) begin
         redundant[i] = (req.value[63-8*i -: 8] == 8'h00 && !req.value[55-8*i]) ||
                        (req.value[63-8*i -: 8] == 8'hFF &&  req.value[55-8*i]);
      end
      start = 3'd0;
      found = 1'b0;
      for (int i = 0; i < 7; i++) begin
         if (!found && redundant[i]) begin
            start = 3'(i + 1);
         end else begin
            found = 1'b1;
         end
      end
   end

   assign int_shifted = req.value << {start, 3'b000};
   assign flags       = req.value[31:0];

   always_comb begin
      if (flags[31:24] != 8'h00) begin
         flag_bytes = 3'd4;
         top_byte   = flags[31:24];
      end else if (flags[23:16] != 8'h00) begin
         flag_bytes = 3'd3;
         top_byte   = flags[23:16];
      end else if (flags[15:8] != 8'h00) begin
         flag_bytes = 3'd2;
         top_byte   = flags[15:8];
      end else begin
         flag_bytes = 3'd1;
         top_byte   = flags[7:0];
      end
      top_pos = 3'd0;
      for (int j = 1; j < 8; j++) begin
         if (top_byte[j]) begin
            top_pos = 3'(j);
         end
      end
   end

   always_comb begin
      if (req.content_length[30:24] != 7'd0) begin
         len_bytes = 3'd4;
      end else if (req.content_length[23:16] != 8'd0) begin
         len_bytes = 3'd3;
      end else if (req.content_length[15:8] != 8'd0) begin
         len_bytes = 3'd2;
      end else begin
         len_bytes = 3'd1;
      end
   end

   // long form length bytes moved to the top of the word, big-endian
   assign len_shifted = {1'b0, req.content_length} << {3'd4 - len_bytes, 3'b000};

   always_comb begin
      frame.data  = '0;
      frame.count = '0;
      frame.error = 1'b0;
      case (req.operation)
         OP_INTEGER: begin
            frame.data[0] = TAG_INTEGER;
            frame.data[1] = 8'd8 - {5'd0, start};
            for (int k = 0; k < 8; k++) begin
               frame.data[2+k] = int_shifted[63-8*k -: 8];
            end
            frame.count = CountWidth'(FrameBytes) - {1'b0, start};
         end
         OP_BOOLEAN: begin
            frame.data[0] = TAG_BOOLEAN;
            frame.data[1] = 8'h01;
            frame.data[2] = (req.value != 64'd0) ? 8'hFF : 8'h00;
            frame.count   = CountWidth'(3);
         end
         OP_BIT_STRING: begin
            frame.data[0] = TAG_BIT_STRING;
            if (flags == 32'd0) begin
               frame.data[1] = 8'h01;
               frame.data[2] = 8'h00;
               frame.count   = CountWidth'(3);
            end else begin
               frame.data[1] = {5'd0, flag_bytes} + 8'd1;
               frame.data[2] = {5'd0, 3'd7 - top_pos};
               for (int i = 0; i < 4; i++) begin
                  frame.data[3+i] = bit_reverse(flags[8*i +: 8]);
               end
               frame.count = CountWidth'(3) + {1'b0, flag_bytes};
            end
         end
         OP_NULL: begin
            frame.data[0] = TAG_NULL;
            frame.data[1] = 8'h00;
            frame.count   = CountWidth'(2);
         end
         OP_HEADER: begin
            if (req.tag_number >= TAG_LIMIT) begin
               frame.error = 1'b1;
               frame.count = CountWidth'(1);
            end else begin
               frame.data[0] = {req.tag_class, req.constructed, req.tag_number[4:0]};
               if (req.content_length[30:7] == 24'd0) begin
                  frame.data[1] = {1'b0, req.content_length[6:0]};
                  frame.count   = CountWidth'(2);
               end else begin
                  frame.data[1] = LONG_FORM | {5'd0, len_bytes};
                  for (int k = 0; k < 4; k++) begin
                     frame.data[2+k] = len_shifted[31-8*k -: 8];
                  end
                  frame.count = CountWidth'(2) + {1'b0, len_bytes};
               end
            end
         end
         default: begin
            frame.count = '0;
         end
      endcase
   end

endmodule

FILE: rtl/core/derenc_serializer.sv
module derenc_serializer (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  load_valid,
   input  derenc_pkg::frame_type load_frame,
   output logic                  load_ready,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [7:0]            rsp_tdata,
   output logic                  rsp_tlast,
   output logic                  rsp_tuser
);
   import derenc_pkg::*;

   logic [FrameBytes-1:0][7:0] data_ff, data_in;
   logic [CountWidth-1:0]      remain_ff, remain_in;
   logic                       error_ff, error_in;
   logic                       busy_ff, busy_in;
   logic                       transfer;
   logic                       load;

   assign transfer   = busy_ff && rsp_tready;
   assign load_ready = !busy_ff || (transfer && rsp_tlast);
   // empty frames (unknown operations) are dropped without a slot
   assign load       = load_valid && load_ready && (load_frame.count != '0);

   always_comb begin
      data_in   = data_ff;
      remain_in = remain_ff;
      error_in  = error_ff;
      busy_in   = busy_ff;
      if (load) begin
         data_in   = load_frame.data;
         remain_in = load_frame.count;
         error_in  = load_frame.error;
         busy_in   = 1'b1;
      end else if (transfer) begin
         data_in   = {8'h00, data_ff[FrameBytes-1:1]};
         remain_in = remain_ff - CountWidth'(1);
         busy_in   = !rsp_tlast;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff   <= 1'b0;
         remain_ff <= '0;
      end else begin
         busy_ff   <= busy_in;
         remain_ff <= remain_in;
      end
      data_ff  <= data_in;
      error_ff <= error_in;
   end

   assign rsp_tvalid = busy_ff;
   assign rsp_tdata  = data_ff[0];
   assign rsp_tlast  = (remain_ff == CountWidth'(1));
   assign rsp_tuser  = error_ff;

endmodule

FILE: rtl/core/der_element_encoder.sv
// channel   dir  tdata                                         tlast      tuser
// req_      in   [63:0] value, [65:64] tag_class,              -          [2:0] operation
//                [66] constructed, [74:67] tag_number,
//                [105:75] content_length, [111:106] zero
// rsp_      out  [7:0] out_byte                                last byte  [0] error
//
// one encoded byte leaves per cycle while rsp_tready is high; an item's encoding
// has 1 to 10 bytes, and the output shifter sets the rate
// a request passes the request register and then the output shifter before its first byte can transfer
// reset clears the valid flags of the request register and the output shifter
// while rsp_tready is low one more request waits in the request register

module der_element_encoder (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_tvalid,
   output logic          req_tready,
   input  logic [111:0]  req_tdata,  // value, tag_class, constructed, tag_number, content_length
   input  logic [2:0]    req_tuser,  // operation
   output logic          rsp_tvalid,
   input  logic          rsp_tready,
   output logic [7:0]    rsp_tdata,  // out_byte
   output logic          rsp_tlast,
   output logic          rsp_tuser   // error
);
   import derenc_pkg::*;

   req_type   req_ff, req_in;
   logic      req_valid_ff, req_valid_in;
   frame_type frame;
   logic      frame_ready;

   assign req_tready = !req_valid_ff || frame_ready;

   always_comb begin
      req_in       = req_ff;
      req_valid_in = req_valid_ff;
      if (req_tready) begin
         req_valid_in          = req_tvalid;
         req_in.operation      = req_tuser;
         req_in.value          = req_tdata[63:0];
         req_in.tag_class      = req_tdata[65:64];
         req_in.constructed    = req_tdata[66];
         req_in.tag_number     = req_tdata[74:67];
         req_in.content_length = req_tdata[105:75];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
      end else begin
         req_valid_ff <= req_valid_in;
      end
      req_ff <= req_in;
   end

   derenc_encode u_encode (
      .req   (req_ff),
      .frame (frame)
   );

   derenc_serializer u_serializer (
      .clock      (clock),
      .reset      (reset),
      .load_valid (req_valid_ff),
      .load_frame (frame),
      .load_ready (frame_ready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser)
   );

   // an error result is a single zero byte
   assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser) |-> (rsp_tlast && rsp_tdata == 8'h00))
      else $error("error result not a lone zero byte");

   // a run of bytes continues until its last byte is taken
   assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tready && !rsp_tlast) |=> rsp_tvalid)
      else $error("byte run broken before last");

   // no output right after reset
   assert property (@(posedge clock)
      $past(reset) |-> !rsp_tvalid)
      else $error("output valid after reset");

   // a request waiting in the register while output is stalled is not replaced
   assert property (@(posedge clock) disable iff (reset)
      (req_valid_ff && !frame_ready) |-> !req_tready)
      else $error("request register overwritten");

endmodule
